/* rtl/sdp_pkg.sv */
`default_nettype none

package sdp_pkg;

    localparam int RADIUS_SQ_W = 23;
    localparam int COEF_W      = 16;
    localparam int STIFF_W     = 16;
    localparam int DENSITY_W   = 32;
    localparam int OFFSET_W    = 12;
    localparam int R2_W        = 24;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam int KERNEL_SHIFT_DEF = 6;
    localparam int QUEUE_DEPTH_DEF  = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_KERNEL_RADIUS_SQUARED = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MASS_KERNEL_COEF      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_STIFFNESS             = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_REST_DENSITY          = 2'd3;

    localparam logic [RADIUS_SQ_W-1:0] RADIUS_SQ_RESET = 23'd4194304;
    localparam logic [COEF_W-1:0]      COEF_RESET      = 16'd256;
    localparam logic [STIFF_W-1:0]     STIFF_RESET     = 16'd256;
    localparam logic [DENSITY_W-1:0]   REST_RESET      = 32'd65536;

    typedef struct packed {
        logic [R2_W-1:0] r2;
        logic            is_self;
        logic            first;
        logic            last;
    } item_t;

    typedef struct packed {
        logic [RADIUS_SQ_W-1:0] radius_sq;
        logic [COEF_W-1:0]      coef;
        logic [STIFF_W-1:0]     stiffness;
        logic [DENSITY_W-1:0]   rest_density;
    } cfg_t;

endpackage

`default_nettype wire

/* rtl/sdp_front.sv */
`default_nettype none

module sdp_front
    import sdp_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [OFFSET_W-1:0] offset_x,
    input  logic signed [OFFSET_W-1:0] offset_y,
    input  logic signed [OFFSET_W-1:0] offset_z,
    input  logic                       is_self,
    input  logic                       first_neighbour,
    input  logic                       last_neighbour,
    input  logic                       q_full,
    output logic                       q_push,
    output item_t                      q_item
);

    logic               stage_valid_reg;
    logic               stage_valid_next;
    logic [22:0]        sq_x_reg;
    logic [22:0]        sq_y_reg;
    logic [22:0]        sq_z_reg;
    logic               self_reg;
    logic               first_reg;
    logic               last_reg;
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic signed [23:0] pz;
    logic               accept;

    assign px = offset_x * offset_x;
    assign py = offset_y * offset_y;
    assign pz = offset_z * offset_z;

    assign q_push   = stage_valid_reg && !q_full;
    assign in_ready = !stage_valid_reg || !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (accept)
        begin
            stage_valid_next = 1'b1;
        end
        else if (q_push)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    // squares are never negative, the top bit of each product is dropped
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sq_x_reg  <= px[22:0];
            sq_y_reg  <= py[22:0];
            sq_z_reg  <= pz[22:0];
            self_reg  <= is_self;
            first_reg <= first_neighbour;
            last_reg  <= last_neighbour;
        end
    end

    assign q_item.r2      = R2_W'(sq_x_reg) + R2_W'(sq_y_reg) + R2_W'(sq_z_reg);
    assign q_item.is_self = self_reg;
    assign q_item.first   = first_reg;
    assign q_item.last    = last_reg;

endmodule

`default_nettype wire

/* rtl/sdp_queue.sv */
`default_nettype none

module sdp_queue
    import sdp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  pop_valid,
    output item_t pop_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    item_t            entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full      = (count_reg == FULL_CNT);
    assign pop_valid = (count_reg != '0);
    assign pop_item  = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_item;
        end
    end

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("queue popped while empty");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != FULL_CNT || pop))
        else $error("queue pushed while full");

endmodule

`default_nettype wire

/* rtl/sdp_back.sv */
`default_nettype none

module sdp_back
    import sdp_pkg::*;
#(
    parameter int KERNEL_SHIFT = KERNEL_SHIFT_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cfg_t                 cfg,
    input  logic                 q_valid,
    input  item_t                q_item,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [DENSITY_W-1:0] density_out,
    output logic [DENSITY_W-1:0] pressure_out
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_KD   = 4'd1;
    localparam logic [3:0] ST_M1   = 4'd2;
    localparam logic [3:0] ST_M2   = 4'd3;
    localparam logic [3:0] ST_M3   = 4'd4;
    localparam logic [3:0] ST_M4   = 4'd5;
    localparam logic [3:0] ST_M5   = 4'd6;
    localparam logic [3:0] ST_ACC  = 4'd7;
    localparam logic [3:0] ST_PRES = 4'd8;
    localparam logic [3:0] ST_EMIT = 4'd9;

    logic [3:0]           state_reg;
    logic [3:0]           state_next;
    logic                 pass_self_reg;
    logic                 pass_self_next;
    logic [DENSITY_W-1:0] acc_reg;
    logic [DENSITY_W-1:0] acc_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    item_t                item_reg;
    item_t                item_next;
    logic [22:0]          d_reg;
    logic [22:0]          d_next;
    logic [45:0]          d2_reg;
    logic [45:0]          d2_next;
    logic [69:0]          cube_reg;
    logic [69:0]          cube_next;
    logic [63:0]          t_reg;
    logic [63:0]          t_next;
    logic [47:0]          p_reg;
    logic [47:0]          p_next;
    logic [DENSITY_W-1:0] density_reg;
    logic [DENSITY_W-1:0] density_next;
    logic [DENSITY_W-1:0] pressure_reg;
    logic [DENSITY_W-1:0] pressure_next;

    logic [23:0]          mul_a;
    logic [23:0]          mul_b;
    logic [47:0]          mul_p;
    logic [R2_W-1:0]      r2_use;
    logic [R2_W-1:0]      h2_ext;
    logic [R2_W-1:0]      h2_diff;
    logic [63:0]          cube_sat;
    logic [47:0]          cube_shift;
    logic [DENSITY_W-1:0] term;
    logic [DENSITY_W:0]   acc_sum;
    logic [DENSITY_W-1:0] acc_sat;
    logic [DENSITY_W-1:0] pres_diff;

    assign r2_use     = pass_self_reg ? '0 : item_reg.r2;
    assign h2_ext     = R2_W'(cfg.radius_sq);
    assign h2_diff    = h2_ext - r2_use;
    assign cube_sat   = (|cube_reg[69:64]) ? '1 : cube_reg[63:0];
    assign cube_shift = cube_sat[63:16];
    assign term       = (|t_reg[63:48]) ? '1 : t_reg[47:16];
    assign acc_sum    = {1'b0, acc_reg} + {1'b0, term};
    assign acc_sat    = acc_sum[DENSITY_W] ? '1 : acc_sum[DENSITY_W-1:0];
    assign pres_diff  = acc_reg - cfg.rest_density;

    // one 24x24 multiplier shared by the cube and coefficient steps
    always_comb
    begin
        case (state_reg)
            ST_M1:
            begin
                mul_a = {1'b0, d_reg};
                mul_b = {1'b0, d_reg};
            end
            ST_M2:
            begin
                mul_a = d2_reg[23:0];
                mul_b = {1'b0, d_reg};
            end
            ST_M3:
            begin
                mul_a = {2'b00, d2_reg[45:24]};
                mul_b = {1'b0, d_reg};
            end
            ST_M4:
            begin
                mul_a = cube_shift[23:0];
                mul_b = {8'd0, cfg.coef};
            end
            ST_M5:
            begin
                mul_a = cube_shift[47:24];
                mul_b = {8'd0, cfg.coef};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign q_pop = (state_reg == ST_IDLE) && q_valid;

    always_comb
    begin
        state_next     = state_reg;
        pass_self_next = pass_self_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg;
        item_next      = item_reg;
        d_next         = d_reg;
        d2_next        = d2_reg;
        cube_next      = cube_reg;
        t_next         = t_reg;
        p_next         = p_reg;
        density_next   = density_reg;
        pressure_next  = pressure_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    item_next      = q_item;
                    pass_self_next = q_item.first;
                    if (q_item.first || !q_item.is_self)
                    begin
                        state_next = ST_KD;
                    end
                    else if (q_item.last)
                    begin
                        state_next = ST_PRES;
                    end
                end
            end
            ST_KD:
            begin
                // out of radius gives a zero term
                if (r2_use > h2_ext)
                begin
                    t_next     = '0;
                    state_next = ST_ACC;
                end
                else
                begin
                    d_next     = 23'(h2_diff >> KERNEL_SHIFT);
                    state_next = ST_M1;
                end
            end
            ST_M1:
            begin
                d2_next    = mul_p[45:0];
                state_next = ST_M2;
            end
            ST_M2:
            begin
                cube_next  = 70'(mul_p);
                state_next = ST_M3;
            end
            ST_M3:
            begin
                cube_next  = cube_reg + (70'(mul_p) << 24);
                state_next = ST_M4;
            end
            ST_M4:
            begin
                t_next     = 64'(mul_p);
                state_next = ST_M5;
            end
            ST_M5:
            begin
                t_next     = t_reg + (64'(mul_p) << 24);
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (pass_self_reg)
                begin
                    // self term loaded, then the entry itself unless it is self
                    acc_next       = term;
                    pass_self_next = 1'b0;
                    if (!item_reg.is_self)
                    begin
                        state_next = ST_KD;
                    end
                    else
                    begin
                        state_next = item_reg.last ? ST_PRES : ST_IDLE;
                    end
                end
                else
                begin
                    acc_next   = acc_sat;
                    state_next = item_reg.last ? ST_PRES : ST_IDLE;
                end
            end
            ST_PRES:
            begin
                if (acc_reg > cfg.rest_density)
                begin
                    p_next = pres_diff * cfg.stiffness;
                end
                else
                begin
                    p_next = '0;
                end
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    density_next   = acc_reg;
                    pressure_next  = (|p_reg[47:40]) ? '1 : p_reg[39:8];
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pass_self_reg <= 1'b0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pass_self_reg <= pass_self_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        d_reg        <= d_next;
        d2_reg       <= d2_next;
        cube_reg     <= cube_next;
        t_reg        <= t_next;
        p_reg        <= p_next;
        density_reg  <= density_next;
        pressure_reg <= pressure_next;
    end

    assign out_valid    = out_valid_reg;
    assign density_out  = density_reg;
    assign pressure_out = pressure_reg;

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> state_reg == ST_IDLE)
        else $error("queue popped outside idle");

    a_cube_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_M1 |=> state_reg == ST_M2)
        else $error("cube steps out of order");

    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_EMIT)
        else $error("result shown without emit step");

endmodule

`default_nettype wire

/* rtl/sph_density_pressure_accumulator.sv */
// path: the input stage registers each entry into the queue; the back end skips a self
// entry, runs KD and ACC for one out of radius and KD, M1 to M5 and ACC for one in radius;
// a first entry adds a pass for the self term, a last entry PRES and EMIT for the pressure
// and result register. One entry per back end pass; the 24x24 multiplier is shared.
// reset: asynchronous active low; accumulator clears to zero, registers take their defaults.
`default_nettype none

module sph_density_pressure_accumulator
    import sdp_pkg::*;
#(
    parameter int KERNEL_SHIFT = KERNEL_SHIFT_DEF,
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write_en,
    input  logic [CFG_INDEX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [OFFSET_W-1:0] offset_x,
    input  logic signed [OFFSET_W-1:0] offset_y,
    input  logic signed [OFFSET_W-1:0] offset_z,
    input  logic                       is_self,
    input  logic                       first_neighbour,
    input  logic                       last_neighbour,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [DENSITY_W-1:0]       density_out,
    output logic [DENSITY_W-1:0]       pressure_out
);

    cfg_t  cfg_reg;
    cfg_t  cfg_next;
    logic  q_push;
    logic  q_pop;
    logic  q_full;
    logic  q_valid;
    item_t push_item;
    item_t pop_item;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            case (cfg_index)
                REG_KERNEL_RADIUS_SQUARED: cfg_next.radius_sq    = cfg_data[RADIUS_SQ_W-1:0];
                REG_MASS_KERNEL_COEF:      cfg_next.coef         = cfg_data[COEF_W-1:0];
                REG_STIFFNESS:             cfg_next.stiffness    = cfg_data[STIFF_W-1:0];
                REG_REST_DENSITY:          cfg_next.rest_density = cfg_data[DENSITY_W-1:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.radius_sq    <= RADIUS_SQ_RESET;
            cfg_reg.coef         <= COEF_RESET;
            cfg_reg.stiffness    <= STIFF_RESET;
            cfg_reg.rest_density <= REST_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    sdp_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .offset_x        (offset_x),
        .offset_y        (offset_y),
        .offset_z        (offset_z),
        .is_self         (is_self),
        .first_neighbour (first_neighbour),
        .last_neighbour  (last_neighbour),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_item          (push_item)
    );

    sdp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_item  (pop_item)
    );

    sdp_back #(
        .KERNEL_SHIFT (KERNEL_SHIFT)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_valid      (q_valid),
        .q_item       (pop_item),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .density_out  (density_out),
        .pressure_out (pressure_out)
    );

endmodule

`default_nettype wire
